@@ design/tsb_pkg.sv @@
// Shared types, constants and helper functions of the texture sampler.
`timescale 1ns / 1ps
package tsb_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int T_W       = FRAC_W + 1;
    localparam int SIZE_W    = 9;
    localparam int IDX_W     = 8;
    localparam int WT_W      = 8;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int TEXEL_W   = 32;
    localparam int PROD_W    = T_W + SIZE_W;
    localparam int WPROD_W   = 2 * WT_W + 1;
    localparam int CPROD_W   = WPROD_W + 8;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(256);
    localparam logic [T_W-1:0]    T_ONE    = T_W'(1) << FRAC_W;

    // Tile modes
    localparam logic [1:0] TILE_CLAMP  = 2'd0;
    localparam logic [1:0] TILE_REPEAT = 2'd1;
    localparam logic [1:0] TILE_MIRROR = 2'd2;
    localparam logic [1:0] TILE_DECAL  = 2'd3;

    // Filters and commands
    localparam logic FILT_NEAREST  = 1'b0;
    localparam logic FILT_BILINEAR = 1'b1;
    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_SAMPLE    = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_XMODE  = 3'd2;
    localparam logic [2:0] REG_YMODE  = 3'd3;
    localparam logic [2:0] REG_FILTER = 3'd4;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [1:0]        x_mode;
        logic [1:0]        y_mode;
        logic              filt;
    } t_cfg;

    // Control and fetch coordinates leaving the coordinate pipeline
    typedef struct packed {
        logic               vld;
        logic               load;
        logic               zero;
        logic               filt;
        logic [IDX_W-1:0]   x0;
        logic [IDX_W-1:0]   x1;
        logic [IDX_W-1:0]   y0;
        logic [IDX_W-1:0]   y1;
        logic [WT_W-1:0]    a;
        logic [WT_W-1:0]    b;
        logic [ADDR_W-1:0]  ld_addr;
        logic [TEXEL_W-1:0] ld_data;
    } t_fetch;

    // Size register to the size actually used
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
        logic [SIZE_W-1:0] s;
        s = r;
        if (r == '0) s = SIZE_W'(1);
        else if (r > MAX_SIZE) s = MAX_SIZE;
        return s;
    endfunction

    // Per-axis coordinate remap; result lies in [0, ONE] for clamp, repeat and mirror
    function automatic logic [T_W-1:0] remap(input logic [COORD_W-1:0] t,
                                             input logic [1:0] mode);
        logic [T_W-1:0] r;
        logic [T_W-1:0] m;
        r = t[T_W-1:0];
        m = {~t[FRAC_W], t[FRAC_W-1:0]};
        case (mode)
            TILE_CLAMP: begin
                if (t[COORD_W-1]) r = '0;
                else if (t[COORD_W-2:FRAC_W] != '0 && t[T_W-1:0] != T_ONE) r = T_ONE;
                else if (t[COORD_W-2:T_W] != '0) r = T_ONE;
                else r = t[T_W-1:0];
            end
            TILE_REPEAT: r = {1'b0, t[FRAC_W-1:0]};
            TILE_MIRROR: begin
                if (m[FRAC_W]) r = {1'b0, m[FRAC_W-1:0]};
                else r = T_ONE - m;
            end
            default: r = t[T_W-1:0];
        endcase
        return r;
    endfunction

    // Clamp a signed index to [0, size-1]
    function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [SIZE_W+2:0] i,
                                                   input logic [SIZE_W-1:0] size);
        logic signed [SIZE_W+2:0] top;
        logic [IDX_W-1:0] r;
        top = $signed({3'b000, size}) - 12'sd1;
        if (i < 0) r = '0;
        else if (i > top) r = top[IDX_W-1:0];
        else r = i[IDX_W-1:0];
        return r;
    endfunction

endpackage

@@ design/tsb_ifs.sv @@
// Stream interfaces for sampler commands and sampled colors.
`timescale 1ns / 1ps
interface tsb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] u_coord;
    logic [31:0] v_coord;
    logic [7:0]  texel_x;
    logic [7:0]  texel_y;
    logic [31:0] texel_data;
    modport source (output valid, cmd, u_coord, v_coord, texel_x, texel_y, texel_data,
                    input ready);
    modport sink (input valid, cmd, u_coord, v_coord, texel_x, texel_y, texel_data,
                  output ready);
endinterface

interface tsb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] color;
    modport source (output valid, color, input ready);
    modport sink (input valid, color, output ready);
endinterface

@@ design/tsb_coord.sv @@
// Coordinate pipeline: remap, scale by texture size, texel indices and weights.
`timescale 1ns / 1ps
module tsb_coord (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic                         i_cmd,
    input  logic [tsb_pkg::COORD_W-1:0]  i_u,
    input  logic [tsb_pkg::COORD_W-1:0]  i_v,
    input  logic [tsb_pkg::IDX_W-1:0]    i_tx,
    input  logic [tsb_pkg::IDX_W-1:0]    i_ty,
    input  logic [tsb_pkg::TEXEL_W-1:0]  i_tdata,
    input  tsb_pkg::t_cfg                i_cfg,
    output tsb_pkg::t_fetch              o_fetch
);
    // stage 1: remap
    logic                          r1_vld, r1_load, r1_zero, r1_filt;
    logic [tsb_pkg::T_W-1:0]       r1_tu, r1_tv;
    logic [tsb_pkg::SIZE_W-1:0]    r1_w, r1_h;
    logic [1:0]                    r1_xm, r1_ym;
    logic [tsb_pkg::ADDR_W-1:0]    r1_addr;
    logic [tsb_pkg::TEXEL_W-1:0]   r1_data;
    logic                          n1_zero;

    // stage 2: scaled coordinates
    logic                          r2_vld, r2_load, r2_zero, r2_filt;
    logic [tsb_pkg::PROD_W-1:0]    r2_pu, r2_pv;
    logic [tsb_pkg::SIZE_W-1:0]    r2_w, r2_h;
    logic [1:0]                    r2_xm, r2_ym;
    logic [tsb_pkg::ADDR_W-1:0]    r2_addr;
    logic [tsb_pkg::TEXEL_W-1:0]   r2_data;

    // stage 3: indices
    tsb_pkg::t_fetch               r3, n3;

    function automatic logic out_of_unit(input logic [tsb_pkg::COORD_W-1:0] t);
        return t[tsb_pkg::COORD_W-1] || (t[tsb_pkg::COORD_W-2:tsb_pkg::FRAC_W] != '0);
    endfunction

    // Index pair and weight along one axis
    function automatic logic [2*tsb_pkg::IDX_W+tsb_pkg::WT_W-1:0] axis(
        input logic [tsb_pkg::PROD_W-1:0] p, input logic [tsb_pkg::SIZE_W-1:0] size,
        input logic [1:0] mode, input logic filt);
        logic signed [tsb_pkg::PROD_W:0]   px;
        logic signed [tsb_pkg::SIZE_W+2:0] i0, nr;
        logic [tsb_pkg::SIZE_W-1:0]        r0, r1;
        logic [tsb_pkg::IDX_W-1:0]         k0, k1;
        px = $signed({1'b0, p}) - $signed((tsb_pkg::PROD_W+1)'(1) << (tsb_pkg::FRAC_W - 1));
        i0 = (tsb_pkg::SIZE_W+3)'(px >>> tsb_pkg::FRAC_W);
        nr = $signed({2'b00, p[tsb_pkg::PROD_W-1:tsb_pkg::FRAC_W]});
        r0 = (i0 < 0) ? size - tsb_pkg::SIZE_W'(1) : i0[tsb_pkg::SIZE_W-1:0];
        r1 = (r0 + tsb_pkg::SIZE_W'(1) == size) ? '0 : r0 + tsb_pkg::SIZE_W'(1);
        if (filt == tsb_pkg::FILT_NEAREST) begin
            k0 = tsb_pkg::clamp_idx(nr, size);
            k1 = k0;
        end else if (mode == tsb_pkg::TILE_REPEAT) begin
            k0 = r0[tsb_pkg::IDX_W-1:0];
            k1 = r1[tsb_pkg::IDX_W-1:0];
        end else begin
            k0 = tsb_pkg::clamp_idx(i0, size);
            k1 = tsb_pkg::clamp_idx(i0 + 12'sd1, size);
        end
        return {k0, k1, px[tsb_pkg::FRAC_W-1:tsb_pkg::FRAC_W-tsb_pkg::WT_W]};
    endfunction

    assign n1_zero = (i_cfg.x_mode == tsb_pkg::TILE_DECAL && out_of_unit(i_u)) ||
                     (i_cfg.y_mode == tsb_pkg::TILE_DECAL && out_of_unit(i_v));

    always_comb begin
        n3         = '0;
        n3.vld     = r2_vld;
        n3.load    = r2_load;
        n3.zero    = r2_zero;
        n3.filt    = r2_filt;
        {n3.x0, n3.x1, n3.a} = axis(r2_pu, r2_w, r2_xm, r2_filt);
        {n3.y0, n3.y1, n3.b} = axis(r2_pv, r2_h, r2_ym, r2_filt);
        n3.ld_addr = r2_addr;
        n3.ld_data = r2_data;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3.vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3.vld <= n3.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_load <= (i_cmd == tsb_pkg::CMD_LOAD);
            r1_zero <= n1_zero;
            r1_filt <= i_cfg.filt;
            r1_tu   <= tsb_pkg::remap(i_u, i_cfg.x_mode);
            r1_tv   <= tsb_pkg::remap(i_v, i_cfg.y_mode);
            r1_w    <= tsb_pkg::eff_size(i_cfg.width);
            r1_h    <= tsb_pkg::eff_size(i_cfg.height);
            r1_xm   <= i_cfg.x_mode;
            r1_ym   <= i_cfg.y_mode;
            r1_addr <= {i_ty, i_tx};
            r1_data <= i_tdata;

            r2_load <= r1_load;
            r2_zero <= r1_zero;
            r2_filt <= r1_filt;
            r2_pu   <= tsb_pkg::PROD_W'(r1_tu * r1_w);
            r2_pv   <= tsb_pkg::PROD_W'(r1_tv * r1_h);
            r2_w    <= r1_w;
            r2_h    <= r1_h;
            r2_xm   <= r1_xm;
            r2_ym   <= r1_ym;
            r2_addr <= r1_addr;
            r2_data <= r1_data;

            r3.load    <= n3.load;
            r3.zero    <= n3.zero;
            r3.filt    <= n3.filt;
            r3.x0      <= n3.x0;
            r3.x1      <= n3.x1;
            r3.y0      <= n3.y0;
            r3.y1      <= n3.y1;
            r3.a       <= n3.a;
            r3.b       <= n3.b;
            r3.ld_addr <= n3.ld_addr;
            r3.ld_data <= n3.ld_data;
        end
    end

    assign o_fetch = r3;

endmodule

@@ design/tsb_texel_ram.sv @@
// One copy of the texel store: one write port, one registered read port.
`timescale 1ns / 1ps
module tsb_texel_ram (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_we,
    input  logic [tsb_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [tsb_pkg::TEXEL_W-1:0] i_wdata,
    input  logic [tsb_pkg::ADDR_W-1:0]  i_raddr,
    output logic [tsb_pkg::TEXEL_W-1:0] o_rdata
);
    logic [tsb_pkg::TEXEL_W-1:0] r_mem [0:(1 << tsb_pkg::ADDR_W)-1];
    logic [tsb_pkg::TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tsb_filter.sv @@
// Filter pipeline: weight products, per-channel blend, rounding, output register.
`timescale 1ns / 1ps
module tsb_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  tsb_pkg::t_fetch             i_fetch,
    input  logic [tsb_pkg::TEXEL_W-1:0] i_c00,
    input  logic [tsb_pkg::TEXEL_W-1:0] i_c10,
    input  logic [tsb_pkg::TEXEL_W-1:0] i_c01,
    input  logic [tsb_pkg::TEXEL_W-1:0] i_c11,
    output logic                        o_vld,
    output logic [tsb_pkg::TEXEL_W-1:0] o_color
);
    localparam int WONE = 1 << tsb_pkg::WT_W;
    localparam int SUM_W = tsb_pkg::CPROD_W + 2;

    // stage 4: weights, aligned with texel read data
    logic                          r4_vld, r4_smp, r4_zero, r4_filt;
    logic [tsb_pkg::WPROD_W-1:0]   r4_w00, r4_w10, r4_w01, r4_w11;
    logic [tsb_pkg::WT_W:0]        n_ia, n_ib, n_a, n_b;

    // stage 5: channel products
    logic                          r5_vld, r5_smp, r5_zero, r5_filt;
    logic [tsb_pkg::CPROD_W-1:0]   r5_p [0:3][0:3];
    logic [tsb_pkg::TEXEL_W-1:0]   r5_near;

    // stage 6: output register
    logic                          r_vld;
    logic [tsb_pkg::TEXEL_W-1:0]   r_color, n_color;

    assign n_a  = {1'b0, i_fetch.a};
    assign n_b  = {1'b0, i_fetch.b};
    assign n_ia = (tsb_pkg::WT_W+1)'(WONE) - n_a;
    assign n_ib = (tsb_pkg::WT_W+1)'(WONE) - n_b;

    // Sum, round and saturate each channel, unless the sample is zeroed or nearest
    always_comb begin
        logic [SUM_W-1:0] s;
        n_color = '0;
        for (int ch = 0; ch < 4; ch++) begin
            s = SUM_W'(r5_p[ch][0]) + SUM_W'(r5_p[ch][1]) + SUM_W'(r5_p[ch][2])
              + SUM_W'(r5_p[ch][3]) + (SUM_W'(1) << (2 * tsb_pkg::WT_W - 1));
            s = s >> (2 * tsb_pkg::WT_W);
            n_color[ch*8 +: 8] = (s > SUM_W'(255)) ? 8'hFF : s[7:0];
        end
        if (r5_zero) n_color = '0;
        else if (r5_filt == tsb_pkg::FILT_NEAREST) n_color = r5_near;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else if (i_en) begin
            r4_vld <= i_fetch.vld;
            r5_vld <= r4_vld;
            r_vld  <= r5_vld && r5_smp;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_smp  <= !i_fetch.load;
            r4_zero <= i_fetch.zero;
            r4_filt <= i_fetch.filt;
            r4_w00  <= tsb_pkg::WPROD_W'(n_ia * n_ib);
            r4_w10  <= tsb_pkg::WPROD_W'(n_a * n_ib);
            r4_w01  <= tsb_pkg::WPROD_W'(n_ia * n_b);
            r4_w11  <= tsb_pkg::WPROD_W'(n_a * n_b);

            r5_smp  <= r4_smp;
            r5_zero <= r4_zero;
            r5_filt <= r4_filt;
            r5_near <= i_c00;
            for (int ch = 0; ch < 4; ch++) begin
                r5_p[ch][0] <= tsb_pkg::CPROD_W'(i_c00[ch*8 +: 8] * r4_w00);
                r5_p[ch][1] <= tsb_pkg::CPROD_W'(i_c10[ch*8 +: 8] * r4_w10);
                r5_p[ch][2] <= tsb_pkg::CPROD_W'(i_c01[ch*8 +: 8] * r4_w01);
                r5_p[ch][3] <= tsb_pkg::CPROD_W'(i_c11[ch*8 +: 8] * r4_w11);
            end

            r_color <= n_color;
        end
    end

    assign o_vld   = r_vld;
    assign o_color = r_color;

endmodule

@@ design/texture_sampler_tiled_bilinear_unit.sv @@
// Top level of the tiled bilinear texture sampler.
//
// Channels: i_in carries load and sample transactions (valid/ready), o_out
// carries one color per sample transaction; loads give no result. Registers
// (width, height, x/y tile mode, filter) at APB byte addresses 0,4,8,12,16
// are written by the user only while the unit is idle; nothing enforces it.
// Pipeline: six register stages (remap, scale, index, texel read, channel
// products, blend) lie between accepting a sample and raising o_out.valid.
// Throughput: one transaction per cycle unless o_out stalls. The texel store
// is kept in four identical copies written together, so the four bilinear
// taps are read in the same cycle; a load updates the store in the read
// stage, so any later sample sees it.
// Reset: valid bits and registers clear (size 256x256, clamp, nearest). The
// texel store is not cleared; a texel must be loaded before it is sampled.
// Stall: while a color waits on o_out the whole pipeline holds and i_in.ready
// is low; nothing is lost or repeated.
`timescale 1ns / 1ps
module texture_sampler_tiled_bilinear_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tsb_in_if.sink                       i_in,
    tsb_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tsb_pkg::APB_AW-1:0]   paddr,
    input  logic [tsb_pkg::APB_DW-1:0]   pwdata,
    output logic [tsb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    tsb_pkg::t_cfg                 r_cfg;
    tsb_pkg::t_fetch               w_fetch;
    logic                          w_en, w_out_vld, w_we;
    logic [2:0]                    w_idx;
    logic [tsb_pkg::TEXEL_W-1:0]   w_c00, w_c10, w_c01, w_c11;

    // Whole pipeline advances unless a color is held
    assign w_en       = !w_out_vld || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = w_out_vld;

    // Register file
    assign pready = 1'b1;
    assign w_idx  = paddr[tsb_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= tsb_pkg::MAX_SIZE;
            r_cfg.height <= tsb_pkg::MAX_SIZE;
            r_cfg.x_mode <= tsb_pkg::TILE_CLAMP;
            r_cfg.y_mode <= tsb_pkg::TILE_CLAMP;
            r_cfg.filt   <= tsb_pkg::FILT_NEAREST;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                tsb_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[tsb_pkg::SIZE_W-1:0];
                tsb_pkg::REG_HEIGHT: r_cfg.height <= pwdata[tsb_pkg::SIZE_W-1:0];
                tsb_pkg::REG_XMODE:  r_cfg.x_mode <= pwdata[1:0];
                tsb_pkg::REG_YMODE:  r_cfg.y_mode <= pwdata[1:0];
                tsb_pkg::REG_FILTER: r_cfg.filt   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tsb_pkg::REG_WIDTH:  prdata = tsb_pkg::APB_DW'(r_cfg.width);
            tsb_pkg::REG_HEIGHT: prdata = tsb_pkg::APB_DW'(r_cfg.height);
            tsb_pkg::REG_XMODE:  prdata = tsb_pkg::APB_DW'(r_cfg.x_mode);
            tsb_pkg::REG_YMODE:  prdata = tsb_pkg::APB_DW'(r_cfg.y_mode);
            tsb_pkg::REG_FILTER: prdata = tsb_pkg::APB_DW'(r_cfg.filt);
            default:             prdata = '0;
        endcase
    end

    // Stages 1..3
    tsb_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_cmd   (i_in.cmd),
        .i_u     (i_in.u_coord),
        .i_v     (i_in.v_coord),
        .i_tx    (i_in.texel_x),
        .i_ty    (i_in.texel_y),
        .i_tdata (i_in.texel_data),
        .i_cfg   (r_cfg),
        .o_fetch (w_fetch)
    );

    // Stage 4: texel store copies, one per bilinear tap
    assign w_we = w_en && w_fetch.vld && w_fetch.load;

    tsb_texel_ram u_ram00 (
        .i_clk (i_clk), .i_en (w_en), .i_we (w_we),
        .i_waddr (w_fetch.ld_addr), .i_wdata (w_fetch.ld_data),
        .i_raddr ({w_fetch.y0, w_fetch.x0}), .o_rdata (w_c00)
    );
    tsb_texel_ram u_ram10 (
        .i_clk (i_clk), .i_en (w_en), .i_we (w_we),
        .i_waddr (w_fetch.ld_addr), .i_wdata (w_fetch.ld_data),
        .i_raddr ({w_fetch.y0, w_fetch.x1}), .o_rdata (w_c10)
    );
    tsb_texel_ram u_ram01 (
        .i_clk (i_clk), .i_en (w_en), .i_we (w_we),
        .i_waddr (w_fetch.ld_addr), .i_wdata (w_fetch.ld_data),
        .i_raddr ({w_fetch.y1, w_fetch.x0}), .o_rdata (w_c01)
    );
    tsb_texel_ram u_ram11 (
        .i_clk (i_clk), .i_en (w_en), .i_we (w_we),
        .i_waddr (w_fetch.ld_addr), .i_wdata (w_fetch.ld_data),
        .i_raddr ({w_fetch.y1, w_fetch.x1}), .o_rdata (w_c11)
    );

    // Stages 4..6
    tsb_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_fetch (w_fetch),
        .i_c00   (w_c00),
        .i_c10   (w_c10),
        .i_c01   (w_c01),
        .i_c11   (w_c11),
        .o_vld   (w_out_vld),
        .o_color (o_out.color)
    );

endmodule

@@ design/tsb_checker.sv @@
// Port-level checks of the texture sampler, bound to its top level.
`timescale 1ns / 1ps
module tsb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_color
);
    // A held color does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_color))
        else $error("color changed while stalled");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Input is taken exactly when the output side can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

endmodule

bind texture_sampler_tiled_bilinear_unit tsb_checker u_tsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_color     (o_out.color)
);

@@ sim/tb_texture_sampler_tiled_bilinear_unit.sv @@
// Testbench for the tiled bilinear texture sampler: random loads/samples, self-checking.
`timescale 1ns / 1ps
module tb_texture_sampler_tiled_bilinear_unit;

    localparam longint ONE = 64'sd65536;

    typedef struct {
        logic        cmd;
        logic [31:0] u;
        logic [31:0] v;
        logic [7:0]  tx;
        logic [7:0]  ty;
        logic [31:0] data;
    } t_texture_op;

    typedef struct {
        bit zero;
        int x0, x1, y0, y1, a, b;
    } t_tap_set;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [tsb_pkg::APB_AW-1:0] paddr;
    logic [tsb_pkg::APB_DW-1:0] pwdata;
    logic [tsb_pkg::APB_DW-1:0] prdata;
    logic pready;

    tsb_in_if  cmd_if ();
    tsb_out_if color_if ();

    texture_sampler_tiled_bilinear_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (color_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_texture_op    pending_ops[$];
    logic [31:0]    expected_colors[$];
    t_texture_op    cur_op;
    tsb_pkg::t_cfg  cur_cfg;
    logic [31:0]    texels[65536];
    bit             loaded[65536];
    int             send_idle_pct;
    int             recv_stall_pct;
    int             mismatches;
    int             quiet_cycles;

    // Clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int axis_size(input logic [tsb_pkg::SIZE_W-1:0] r);
        if (r == 0) return 1;
        if (r > 256) return 256;
        return int'(r);
    endfunction

    function automatic int clamp_index(input longint i, input int size);
        if (i < 0) return 0;
        if (i > size - 1) return size - 1;
        return int'(i);
    endfunction

    function automatic int wrap_index(input longint i, input int size);
        longint r;
        r = i % size;
        if (r < 0) r += size;
        return int'(r);
    endfunction

    function automatic longint tile_remap(input longint t, input logic [1:0] mode);
        longint m;
        case (mode)
            tsb_pkg::TILE_CLAMP: begin
                if (t < 0) return 0;
                if (t > ONE) return ONE;
                return t;
            end
            tsb_pkg::TILE_REPEAT: return t & (ONE - 1);
            tsb_pkg::TILE_MIRROR: begin
                m = ((t - ONE) & (2 * ONE - 1)) - ONE;
                return (m < 0) ? -m : m;
            end
            default: return t;
        endcase
    endfunction

    // Texel indices and weight along one axis
    function automatic void axis_taps(input longint t, input int size, input logic [1:0] mode,
                                      input logic filt, output int i0, output int i1,
                                      output int wt);
        longint p, f;
        if (filt == tsb_pkg::FILT_NEAREST) begin
            i0 = clamp_index((t * size) >>> 16, size);
            i1 = i0;
            wt = 0;
        end else begin
            p  = t * size - ONE / 2;
            f  = p >>> 16;
            wt = int'((p & (ONE - 1)) >> 8);
            if (mode == tsb_pkg::TILE_REPEAT) begin
                i0 = wrap_index(f, size);
                i1 = wrap_index(i0 + 1, size);
            end else begin
                i1 = clamp_index(f + 1, size);
                i0 = clamp_index(f, size);
            end
        end
    endfunction

    function automatic t_tap_set locate_taps(input tsb_pkg::t_cfg c, input logic [31:0] u,
                                             input logic [31:0] v);
        t_tap_set r;
        longint su, sv;
        su = longint'($signed(u));
        sv = longint'($signed(v));
        r = '{default: 0};
        if ((c.x_mode == tsb_pkg::TILE_DECAL && (su < 0 || su >= ONE)) ||
            (c.y_mode == tsb_pkg::TILE_DECAL && (sv < 0 || sv >= ONE))) begin
            r.zero = 1'b1;
            return r;
        end
        axis_taps(tile_remap(su, c.x_mode), axis_size(c.width), c.x_mode, c.filt,
                  r.x0, r.x1, r.a);
        axis_taps(tile_remap(sv, c.y_mode), axis_size(c.height), c.y_mode, c.filt,
                  r.y0, r.y1, r.b);
        return r;
    endfunction

    // Per-channel weighted blend of the four taps (nearest: all weight on one tap)
    function automatic logic [31:0] shade(input t_tap_set t);
        logic [31:0] c00, c10, c01, c11, r;
        int s;
        if (t.zero) return 32'h0;
        c00 = texels[t.y0 * 256 + t.x0];
        c10 = texels[t.y0 * 256 + t.x1];
        c01 = texels[t.y1 * 256 + t.x0];
        c11 = texels[t.y1 * 256 + t.x1];
        for (int ch = 0; ch < 4; ch++) begin
            s = int'(c00[ch*8 +: 8]) * (256 - t.a) * (256 - t.b) +
                int'(c10[ch*8 +: 8]) * t.a * (256 - t.b) +
                int'(c01[ch*8 +: 8]) * (256 - t.a) * t.b +
                int'(c11[ch*8 +: 8]) * t.a * t.b;
            s = (s + 32768) >> 16;
            if (s > 255) s = 255;
            r[ch*8 +: 8] = s[7:0];
        end
        return r;
    endfunction

    // Command driver; prediction runs on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                if (cur_op.cmd == tsb_pkg::CMD_LOAD)
                    texels[{cur_op.ty, cur_op.tx}] = cur_op.data;
                else
                    expected_colors.push_back(shade(locate_taps(cur_cfg, cur_op.u, cur_op.v)));
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_op = pending_ops.pop_front();
                    cmd_if.valid      <= 1'b1;
                    cmd_if.cmd        <= cur_op.cmd;
                    cmd_if.u_coord    <= cur_op.u;
                    cmd_if.v_coord    <= cur_op.v;
                    cmd_if.texel_x    <= cur_op.tx;
                    cmd_if.texel_y    <= cur_op.ty;
                    cmd_if.texel_data <= cur_op.data;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Color monitor and random back-pressure
    always @(posedge i_clk) begin
        logic [31:0] want;
        color_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && color_if.valid && color_if.ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected color: expected none, actual %h", $time,
                         color_if.color);
                mismatches++;
            end else begin
                want = expected_colors.pop_front();
                if (color_if.color !== want) begin
                    $display("%0t: color mismatch: expected %h, actual %h", $time, want,
                             color_if.color);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (color_if.valid && color_if.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int w, input int h, input logic [1:0] xm,
                              input logic [1:0] ym, input logic filt);
        write_reg(tsb_pkg::REG_WIDTH, w);
        write_reg(tsb_pkg::REG_HEIGHT, h);
        write_reg(tsb_pkg::REG_XMODE, 32'(xm));
        write_reg(tsb_pkg::REG_YMODE, 32'(ym));
        write_reg(tsb_pkg::REG_FILTER, 32'(filt));
        cur_cfg.width  = w[tsb_pkg::SIZE_W-1:0];
        cur_cfg.height = h[tsb_pkg::SIZE_W-1:0];
        cur_cfg.x_mode = xm;
        cur_cfg.y_mode = ym;
        cur_cfg.filt   = filt;
    endtask

    // Wait until every queued transaction is sent and every color has come back
    task automatic wait_drained();
        while (pending_ops.size() > 0 || cmd_if.valid || expected_colors.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic push_load(input int x, input int y, input logic [31:0] data);
        t_texture_op op;
        op = '{cmd: tsb_pkg::CMD_LOAD, u: $urandom, v: $urandom, tx: x[7:0], ty: y[7:0],
               data: data};
        loaded[y * 256 + x] = 1'b1;
        pending_ops.push_back(op);
    endtask

    task automatic push_sample(input logic [31:0] u, input logic [31:0] v);
        t_texture_op op;
        op = '{cmd: tsb_pkg::CMD_SAMPLE, u: u, v: v, tx: $urandom, ty: $urandom,
               data: $urandom};
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] edges[6] = '{32'h0, 32'h10000, 32'hFFFF, 32'hFFFFFFFF,
                                  32'h7FFFFFFF, 32'h80000000};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return edges[$urandom_range(0, 5)];
            2, 3: return 32'($urandom_range(0, 4096)) - 32'd2048;
            default: return 32'($urandom_range(0, 6 * 65536)) - 32'd196608;
        endcase
    endfunction

    // Random sample whose taps were all loaded; falls back to a load
    task automatic random_sample(input int lw, input int lh);
        t_tap_set t;
        logic [31:0] u, v;
        for (int n = 0; n < 40; n++) begin
            u = rand_coord();
            v = rand_coord();
            t = locate_taps(cur_cfg, u, v);
            if (t.zero || (loaded[t.y0*256+t.x0] && loaded[t.y0*256+t.x1] &&
                           loaded[t.y1*256+t.x0] && loaded[t.y1*256+t.x1])) begin
                push_sample(u, v);
                return;
            end
        end
        push_load($urandom_range(0, lw - 1), $urandom_range(0, lh - 1), $urandom);
    endtask

    initial begin
        int pw[12] = '{2, 1, 3, 0, 511, 5, 16, 256, 7, 4, 300, 8};
        int ph[12] = '{3, 256, 1, 2, 0, 6, 4, 300, 511, 8, 1, 5};
        int send_pct[4] = '{0, 72, 0, 35};
        int recv_pct[4] = '{0, 0, 72, 35};
        int lw, lh;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.cmd     = tsb_pkg::CMD_LOAD;
        cmd_if.u_coord = '0;
        cmd_if.v_coord = '0;
        cmd_if.texel_x = '0;
        cmd_if.texel_y = '0;
        cmd_if.texel_data = '0;
        color_if.ready = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners of a full-size texture, coordinate extremes
        set_config(256, 256, tsb_pkg::TILE_CLAMP, tsb_pkg::TILE_CLAMP, tsb_pkg::FILT_NEAREST);
        push_load(0, 0, 32'h00000000);
        push_load(255, 255, 32'hFFFFFFFF);
        push_load(0, 255, 32'hA5A5A5A5);
        push_load(255, 0, 32'h5A5A5A5A);
        push_load(1, 0, 32'h01234567);
        push_sample(32'h0, 32'h0);
        push_sample(32'h10000, 32'h10000);
        push_sample(32'h7FFFFFFF, 32'h80000000);
        push_sample(32'h80000000, 32'h7FFFFFFF);
        push_sample(32'hFFFF, 32'h0);
        push_sample(32'h100, 32'h0);
        push_sample(32'hFFFFFFFF, 32'hFFFF);
        wait_drained();
        set_config(256, 256, tsb_pkg::TILE_DECAL, tsb_pkg::TILE_MIRROR,
                   tsb_pkg::FILT_BILINEAR);
        // second row of the bilinear footprint near the origin
        push_load(0, 1, 32'h3C6F90C3);
        push_load(1, 1, 32'hE1127B44);
        push_sample(32'hFFFFFFFF, 32'h0);
        push_sample(32'h10000, 32'h0);
        push_sample(32'h80, 32'h80);
        push_sample(32'h0, 32'hFFFFFF80);
        wait_drained();

        // Random phases over sizes, tile modes, filters and idling
        for (int p = 0; p < 12; p++) begin
            send_idle_pct  = send_pct[p % 4];
            recv_stall_pct = recv_pct[p % 4];
            set_config(pw[p], ph[p], 2'(p % 4), 2'((p / 4 + p) % 4), 1'((p / 2) % 2));
            lw = axis_size(cur_cfg.width);
            lh = axis_size(cur_cfg.height);
            if (lw > 8) lw = 8;
            if (lh > 8) lh = 8;
            foreach (loaded[i]) loaded[i] = 1'b0;
            for (int y = 0; y < lh; y++)
                for (int x = 0; x < lw; x++)
                    push_load(x, y, $urandom);
            for (int n = 0; n < 84; n++) begin
                if (p == 3 && n == 42)
                    wait_drained();
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                else
                    random_sample(lw, lh);
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ texture_sampler_tiled_bilinear_unit.f @@
design/tsb_pkg.sv
design/tsb_ifs.sv
design/tsb_coord.sv
design/tsb_texel_ram.sv
design/tsb_filter.sv
design/texture_sampler_tiled_bilinear_unit.sv
design/tsb_checker.sv
sim/tb_texture_sampler_tiled_bilinear_unit.sv
